@@ rtl/bnds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block nesting depth scanner - shared definitions
// Keyword tables, character codes, the depth range and the command that the
// lexer front end passes to the depth back end.
// ---------------------------------------------------------------------------
package bnds_pkg;

	// Depth range; the reported level is the low byte of the depth.
	localparam int unsigned MAX_LEVEL = 255;
	localparam int unsigned DEPTH_W   = $clog2(MAX_LEVEL + 1);
	localparam int unsigned LEVEL_W   = 8;
	localparam int unsigned BYTE_W    = 8;

	// Command queue between front and back.
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Character codes.
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Keyword table.
	localparam int unsigned KW_COUNT = 12;
	localparam int unsigned KW_POS   = 8;
	localparam int unsigned KW_IW    = $clog2(KW_COUNT);

	localparam logic [KW_IW-1:0] KW_BEGIN = 4'd0;
	localparam logic [KW_IW-1:0] KW_DO    = 4'd4;
	localparam logic [KW_IW-1:0] KW_END   = 4'd5;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_POS] = '{
		'{"b", "e", "g", "i", "n", 8'h00, 8'h00, 8'h00},
		'{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "l", "a", "s", "s", 8'h00, 8'h00, 8'h00},
		'{"d", "e", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "o", "d", "u", "l", "e", 8'h00, 8'h00},
		'{"u", "n", "l", "e", "s", "s", 8'h00, 8'h00},
		'{"u", "n", "t", "i", "l", 8'h00, 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
	};

	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd5, 3'd4, 3'd5, 3'd3, 3'd2, 3'd3, 3'd3, 3'd2, 3'd6, 3'd6, 3'd5, 3'd5
	};

	// Keywords that may also close the text.
	localparam logic [KW_COUNT-1:0] KW_EOL = 12'b0000_0011_0001;

	// Depth change carried from front to back.
	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_t;

	typedef struct packed {
		step_t step;
		logic  last;
	} cmd_t;

	// Whether a byte may follow a fully matched keyword.
	function automatic logic kw_follow_ok(input logic [KW_IW-1:0] k, input logic [7:0] b);
		logic sp;
		sp = (b == CH_SPACE);
		unique case (k)
			KW_BEGIN: return sp || (b == CH_NL) || (b == CH_HASH);
			KW_DO:    return sp || (b == CH_NL) || (b == CH_HASH) || (b == CH_PIPE);
			KW_END:   return sp || (b == CH_NL) || (b == CH_HASH) || (b == CH_DOT)
				|| (b == CH_RPAREN);
			default:  return sp;
		endcase
	endfunction

	function automatic logic is_word_byte(input logic [7:0] b);
		return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"))
			|| ((b >= "0") && (b <= "9")) || (b == CH_UNDER);
	endfunction

endpackage
`default_nettype wire

@@ rtl/bnds_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block nesting depth scanner - lexer front end
// Tracks strings, comments and keyword candidates and turns each byte into a
// depth command.
// ---------------------------------------------------------------------------
module bnds_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic [bnds_pkg::BYTE_W-1:0]   byte_in,
	input  wire logic                          last_in,
	output bnds_pkg::cmd_t                     cmd
);

	typedef enum logic [1:0] {
		MODE_CODE    = 2'd0,
		MODE_STRING  = 2'd1,
		MODE_COMMENT = 2'd2
	} lex_mode_t;

	lex_mode_t                        mode_q, n_mode;
	logic                             dq_q, n_dq;
	logic                             esc_q, n_esc;
	logic                             prev_word_q;
	logic [bnds_pkg::KW_COUNT-1:0]    cand_q, n_cand;
	logic [2:0]                       mc_q, n_mc;

	logic [bnds_pkg::KW_COUNT-1:0]    hit, fol, nm, first, eol_hit;
	bnds_pkg::step_t                  step_a;
	logic                             in_code;

	always_comb begin
		for (int i = 0; i < bnds_pkg::KW_COUNT; i++) begin
			hit[i]   = cand_q[i] && (bnds_pkg::KW_LEN[i] == mc_q);
			fol[i]   = hit[i] && bnds_pkg::kw_follow_ok(bnds_pkg::KW_IW'(i), byte_in);
			nm[i]    = cand_q[i] && (mc_q < bnds_pkg::KW_LEN[i])
				&& (bnds_pkg::KW_TEXT[i][mc_q] == byte_in);
			first[i] = (bnds_pkg::KW_TEXT[i][0] == byte_in);
		end
	end

	always_comb begin
		logic taken;
		taken   = 1'b0;
		n_mode  = mode_q;
		n_dq    = dq_q;
		n_esc   = esc_q;
		n_cand  = cand_q;
		n_mc    = mc_q;
		step_a  = bnds_pkg::STEP_NONE;
		in_code = 1'b0;
		unique case (mode_q)
			MODE_STRING: begin
				if (esc_q) begin
					n_esc = 1'b0;
				end else if (byte_in == bnds_pkg::CH_BSLASH) begin
					n_esc = 1'b1;
				end else if (byte_in == (dq_q ? bnds_pkg::CH_DQUOTE : bnds_pkg::CH_SQUOTE)) begin
					n_mode = MODE_CODE;
				end
			end
			MODE_COMMENT: begin
				if (byte_in == bnds_pkg::CH_NL) begin
					n_mode = MODE_CODE;
				end
			end
			default: begin
				in_code = 1'b1;
				// Resolve or extend the word being matched.
				if (cand_q != '0) begin
					if (hit != '0) begin
						if (fol != '0) begin
							step_a = hit[bnds_pkg::KW_END] ? bnds_pkg::STEP_DOWN
								: bnds_pkg::STEP_UP;
						end
						n_cand = '0;
						n_mc   = '0;
					end else if (nm != '0) begin
						n_cand = nm;
						n_mc   = mc_q + 3'd1;
						taken  = 1'b1;
					end else begin
						n_cand = '0;
						n_mc   = '0;
					end
				end
				if (!taken) begin
					if ((byte_in == bnds_pkg::CH_DQUOTE) || (byte_in == bnds_pkg::CH_SQUOTE)) begin
						n_mode = MODE_STRING;
						n_dq   = (byte_in == bnds_pkg::CH_DQUOTE);
						n_esc  = 1'b0;
					end else if (byte_in == bnds_pkg::CH_HASH) begin
						n_mode = MODE_COMMENT;
					end else if ((byte_in == bnds_pkg::CH_NL) || (byte_in == bnds_pkg::CH_SPACE)
						|| (byte_in == bnds_pkg::CH_TAB)) begin
						n_mode = mode_q;
					end else begin
						if (!prev_word_q && (first != '0)) begin
							n_cand = first;
							n_mc   = 3'd1;
						end
						if (byte_in == bnds_pkg::CH_LBRACE) begin
							step_a = bnds_pkg::STEP_UP;
						end else if (byte_in == bnds_pkg::CH_RBRACE) begin
							step_a = bnds_pkg::STEP_DOWN;
						end
					end
				end
			end
		endcase
	end

	// A keyword completed by the final byte counts only where end of text
	// is an allowed follower.
	always_comb begin
		for (int i = 0; i < bnds_pkg::KW_COUNT; i++) begin
			eol_hit[i] = n_cand[i] && (bnds_pkg::KW_LEN[i] == n_mc) && bnds_pkg::KW_EOL[i];
		end
		cmd.last = last_in;
		if (in_code && last_in && (eol_hit != '0)) begin
			cmd.step = eol_hit[bnds_pkg::KW_END] ? bnds_pkg::STEP_DOWN : bnds_pkg::STEP_UP;
		end else begin
			cmd.step = step_a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CODE;
			dq_q        <= 1'b0;
			esc_q       <= 1'b0;
			prev_word_q <= 1'b0;
			cand_q      <= '0;
			mc_q        <= '0;
		end else if (accept) begin
			if (last_in) begin
				mode_q      <= MODE_CODE;
				dq_q        <= 1'b0;
				esc_q       <= 1'b0;
				prev_word_q <= 1'b0;
				cand_q      <= '0;
				mc_q        <= '0;
			end else begin
				mode_q      <= n_mode;
				dq_q        <= n_dq;
				esc_q       <= n_esc;
				prev_word_q <= bnds_pkg::is_word_byte(byte_in);
				cand_q      <= n_cand;
				mc_q        <= n_mc;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/bnds_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block nesting depth scanner - command queue
// Small first-in first-out store of depth commands between front and back.
// ---------------------------------------------------------------------------
module bnds_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  bnds_pkg::cmd_t       push_cmd,
	input  wire logic            pop,
	output bnds_pkg::cmd_t       pop_cmd,
	output logic                 full,
	output logic                 empty
);

	bnds_pkg::cmd_t                  mem_q [bnds_pkg::QUEUE_DEPTH];
	logic [bnds_pkg::QUEUE_AW-1:0]   wr_q;
	logic [bnds_pkg::QUEUE_AW-1:0]   rd_q;
	logic [bnds_pkg::QUEUE_CW-1:0]   count_q;

	assign full    = (count_q == bnds_pkg::QUEUE_CW'(bnds_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push)
		else $error("command pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop)
		else $error("command popped from an empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue fill count lost a push");

endmodule
`default_nettype wire

@@ rtl/bnds_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block nesting depth scanner - depth back end
// Applies depth commands with a floor at zero and saturation, clears the depth
// after the final item of a text, and holds the level in the output register.
// ---------------------------------------------------------------------------
module bnds_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_avail,
	input  bnds_pkg::cmd_t                     cmd,
	output logic                               cmd_pop,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bnds_pkg::LEVEL_W-1:0]       out_level
);

	logic [bnds_pkg::DEPTH_W-1:0]                     depth_q;
	logic [bnds_pkg::DEPTH_W-1:0]                     n_depth;
	logic [bnds_pkg::DEPTH_W+bnds_pkg::LEVEL_W-1:0]   depth_ext;
	logic                                             valid_q;
	logic [bnds_pkg::LEVEL_W-1:0]                     level_q;

	assign cmd_pop   = cmd_avail && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_level = level_q;

	always_comb begin
		n_depth = depth_q;
		unique case (cmd.step)
			bnds_pkg::STEP_UP: begin
				if (depth_q < bnds_pkg::DEPTH_W'(bnds_pkg::MAX_LEVEL)) begin
					n_depth = depth_q + 1'b1;
				end
			end
			bnds_pkg::STEP_DOWN: begin
				if (depth_q != '0) begin
					n_depth = depth_q - 1'b1;
				end
			end
			default: begin
				n_depth = depth_q;
			end
		endcase
		depth_ext = {{bnds_pkg::LEVEL_W{1'b0}}, n_depth};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				depth_q <= cmd.last ? '0 : n_depth;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			level_q <= depth_ext[bnds_pkg::LEVEL_W-1:0];
		end
	end

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= bnds_pkg::DEPTH_W'(bnds_pkg::MAX_LEVEL))
		else $error("depth beyond its saturation level");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop && cmd.last |=> depth_q == '0)
		else $error("depth not cleared after the final item of a text");

endmodule
`default_nettype wire

@@ rtl/block_nesting_depth_scanner.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Block nesting depth scanner
// Reads source text one byte per item and reports the block nesting depth
// after every byte.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                         Handshake
//  s_*       in         tdata[7:0] byte_req, tlast last  tvalid/tready
//  m_*       out        tdata[7:0] level                 tvalid/tready
//
// One item is taken per clock cycle while the queue is not full; each
// item gives exactly one result. Each accepted item's command is queued;
// the back end pops it and registers its level when the output side is free.
// The lexer front end updates its state in the cycle it accepts a byte and
// queues a depth command in a four-entry queue; the back end applies it.
// s_tready falls only when that queue is full, so the front keeps taking
// bytes while a result waits for m_tready.
// arst_n clears the lexer, the queue and the depth; tlast clears the lexer
// and the depth once the last byte of a text has been processed.
//
// Lexing follows the usual rules: quoted strings (single or double, with
// backslash escapes) and comments from '#' to the newline are skipped.
// A keyword is matched byte by byte against the table from a word boundary;
// the byte after a complete keyword decides whether it counts, and for
// begin, do and end the end of the text counts as well. Braces count
// directly. The depth never drops below zero and saturates at MAX_LEVEL.
// ---------------------------------------------------------------------------
module block_nesting_depth_scanner (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] byte_req
	input  wire logic        s_tlast,   // last
	// Output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata    // [7:0] level
);

	logic            accept;
	bnds_pkg::cmd_t  front_cmd;
	bnds_pkg::cmd_t  back_cmd;
	logic            q_full;
	logic            q_empty;
	logic            q_pop;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	bnds_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.byte_in (s_tdata),
		.last_in (s_tlast),
		.cmd     (front_cmd)
	);

	bnds_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_cmd (front_cmd),
		.pop      (q_pop),
		.pop_cmd  (back_cmd),
		.full     (q_full),
		.empty    (q_empty)
	);

	bnds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (!q_empty),
		.cmd       (back_cmd),
		.cmd_pop   (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_level (m_tdata)
	);

endmodule
`default_nettype wire

@@ tb/block_nesting_depth_scanner_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Block nesting depth scanner - self-checking testbench
// Streams short source texts into the scanner, predicts the nesting level
// after every byte with an independent lexer model kept in step with the
// accepted items, and compares each level item that leaves the block with
// the oldest prediction still outstanding.
// ---------------------------------------------------------------------------
module block_nesting_depth_scanner_tb;

	// Traffic shapes. Each queued byte carries the shape that was in force
	// when it was generated, so the gaps follow the stimulus phases.
	typedef enum logic [1:0] {
		PH_STEADY      = 2'd0,
		PH_SEND_GAPS   = 2'd1,
		PH_RECV_STALLS = 2'd2,
		PH_BOTH        = 2'd3
	} phase_t;

	// Lexer modes of the prediction.
	typedef enum logic [1:0] {
		LEX_CODE    = 2'd0,
		LEX_STRING  = 2'd1,
		LEX_COMMENT = 2'd2
	} lex_mode_t;

	// One byte waiting to be offered; hold makes the sender wait until every
	// level already owed by the block has come back.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		phase_t     phase;
		logic       hold;
	} src_item_t;

	// Keyword spellings, right-aligned in six character slots, and lengths.
	localparam logic [8*6-1:0] KW_SPELL [bnds_pkg::KW_COUNT] = '{
		"begin", "case", "class", "def", "do", "end",
		"for", "if", "module", "unless", "until", "while"
	};
	localparam int KW_SIZE [bnds_pkg::KW_COUNT] = '{5, 4, 5, 3, 2, 3, 3, 2, 6, 6, 5, 5};

	localparam string WORD_POOL  = "abcdefghilmnorstuwxyzAZ09_";
	localparam string PUNCT_POOL = "|.)(;=,";
	localparam string SPACE_POOL = " \n\t";

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;   // [7:0] byte_req
	logic       s_tlast  = 1'b0;    // last
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;            // [7:0] level

	block_nesting_depth_scanner u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Stimulus and scoreboard storage.
	src_item_t  bytes_to_send [$];
	logic [7:0] levels_due [$];
	logic [7:0] text_buf [$];
	int         mismatch_count = 0;

	// Generator context: the shape stamped onto new items, and a one-shot
	// request that the next item waits for the block to drain.
	phase_t     fill_phase = PH_STEADY;
	logic       fill_hold  = 1'b0;

	// Shape of the item most recently offered; the receiver stalls by it.
	phase_t     idle_phase = PH_STEADY;

	// Driver and monitor scratch.
	logic       drv_busy;
	src_item_t  head_item;
	logic [7:0] want_level;

	// -----------------------------------------------------------------------
	// Lexer model state, the same pieces the block keeps.
	// -----------------------------------------------------------------------
	int unsigned                    nest_depth;
	lex_mode_t                      lex_mode;
	logic                           in_dquote;
	logic                           escape_next;
	logic                           prev_word;
	logic [bnds_pkg::KW_COUNT-1:0]  kw_live;
	int                             kw_matched;

	function automatic void clear_scan_state();
		nest_depth  = 0;
		lex_mode    = LEX_CODE;
		in_dquote   = 1'b0;
		escape_next = 1'b0;
		prev_word   = 1'b0;
		kw_live     = '0;
		kw_matched  = 0;
	endfunction

	function automatic logic [7:0] kw_char(input int k, input int pos);
		return KW_SPELL[k][8*(KW_SIZE[k]-1-pos) +: 8];
	endfunction

	function automatic logic word_char(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z")
			|| (b >= "0" && b <= "9") || b == bnds_pkg::CH_UNDER;
	endfunction

	// Bytes that let a complete keyword count.
	function automatic logic follow_allowed(input int k, input logic [7:0] b);
		logic common;
		common = (b == bnds_pkg::CH_SPACE);
		if (k == bnds_pkg::KW_BEGIN)
			return common || b == bnds_pkg::CH_NL || b == bnds_pkg::CH_HASH;
		else if (k == bnds_pkg::KW_DO)
			return common || b == bnds_pkg::CH_NL || b == bnds_pkg::CH_HASH
				|| b == bnds_pkg::CH_PIPE;
		else if (k == bnds_pkg::KW_END)
			return common || b == bnds_pkg::CH_NL || b == bnds_pkg::CH_HASH
				|| b == bnds_pkg::CH_DOT || b == bnds_pkg::CH_RPAREN;
		return common;
	endfunction

	function automatic void bump_depth(input logic up);
		if (up) begin
			if (nest_depth < bnds_pkg::MAX_LEVEL)
				nest_depth++;
		end else if (nest_depth > 0) begin
			nest_depth--;
		end
	endfunction

	// Index of a keyword that has matched in full, or -1.
	function automatic int completed_kw();
		for (int i = 0; i < bnds_pkg::KW_COUNT; i++)
			if (kw_live[i] && KW_SIZE[i] == kw_matched)
				return i;
		return -1;
	endfunction

	// Advances the lexer model by one byte and returns the level reported
	// for it. A byte flagged as last resets the model after the level is
	// taken.
	function automatic logic [7:0] level_after_byte(input logic [7:0] b, input logic fin);
		int                            full;
		logic                          taken;
		logic [bnds_pkg::KW_COUNT-1:0] nm;
		logic [7:0]                    level;
		taken = 1'b0;
		nm    = '0;
		case (lex_mode)
			LEX_STRING: begin
				if (escape_next)
					escape_next = 1'b0;
				else if (b == bnds_pkg::CH_BSLASH)
					escape_next = 1'b1;
				else if (b == (in_dquote ? bnds_pkg::CH_DQUOTE : bnds_pkg::CH_SQUOTE))
					lex_mode = LEX_CODE;
			end
			LEX_COMMENT: begin
				if (b == bnds_pkg::CH_NL)
					lex_mode = LEX_CODE;
			end
			default: begin
				if (kw_live != '0) begin
					full = completed_kw();
					if (full >= 0) begin
						// The byte after a whole keyword decides it, then is
						// lexed as usual below.
						if (follow_allowed(full, b))
							bump_depth(full != bnds_pkg::KW_END);
						kw_live    = '0;
						kw_matched = 0;
					end else begin
						for (int i = 0; i < bnds_pkg::KW_COUNT; i++)
							if (kw_live[i] && kw_matched < KW_SIZE[i]
									&& kw_char(i, kw_matched) == b)
								nm[i] = 1'b1;
						if (nm != '0) begin
							kw_live    = nm;
							kw_matched = kw_matched + 1;
							taken      = 1'b1;
						end else begin
							kw_live    = '0;
							kw_matched = 0;
						end
					end
				end
				if (!taken) begin
					if (b == bnds_pkg::CH_DQUOTE || b == bnds_pkg::CH_SQUOTE) begin
						lex_mode    = LEX_STRING;
						in_dquote   = (b == bnds_pkg::CH_DQUOTE);
						escape_next = 1'b0;
					end else if (b == bnds_pkg::CH_HASH) begin
						lex_mode = LEX_COMMENT;
					end else if (b != bnds_pkg::CH_NL && b != bnds_pkg::CH_SPACE
							&& b != bnds_pkg::CH_TAB) begin
						if (!prev_word) begin
							nm = '0;
							for (int i = 0; i < bnds_pkg::KW_COUNT; i++)
								if (kw_char(i, 0) == b)
									nm[i] = 1'b1;
							if (nm != '0) begin
								kw_live    = nm;
								kw_matched = 1;
							end
						end
						if (b == bnds_pkg::CH_LBRACE)
							bump_depth(1'b1);
						else if (b == bnds_pkg::CH_RBRACE)
							bump_depth(1'b0);
					end
				end
				// Only begin, do and end may close the text.
				if (fin && kw_live != '0) begin
					full = completed_kw();
					if (full == bnds_pkg::KW_BEGIN || full == bnds_pkg::KW_DO
							|| full == bnds_pkg::KW_END)
						bump_depth(full != bnds_pkg::KW_END);
				end
			end
		endcase
		prev_word = word_char(b);
		level     = nest_depth[7:0];
		if (fin)
			clear_scan_state();
		return level;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus generation. Texts are assembled in text_buf and then moved
	// to the send queue with last set on their final byte.
	// -----------------------------------------------------------------------
	function automatic logic [7:0] rand_byte();
		logic [31:0] r;
		r = $urandom_range(1, 255);
		return r[7:0];
	endfunction

	function automatic logic [7:0] pick(input string pool);
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	function automatic logic [7:0] valid_follow(input int k);
		if (k == bnds_pkg::KW_BEGIN)
			return pick("\n #");
		else if (k == bnds_pkg::KW_DO)
			return pick("\n #|");
		else if (k == bnds_pkg::KW_END)
			return pick("\n #.)");
		return bnds_pkg::CH_SPACE;
	endfunction

	task automatic put(input logic [7:0] b);
		text_buf.push_back(b);
	endtask

	task automatic put_str(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	task automatic put_word(input int k, input int n);
		for (int i = 0; i < n; i++)
			put(kw_char(k, i));
	endtask

	task automatic flush_text();
		src_item_t it;
		while (text_buf.size() != 0) begin
			it.data   = text_buf.pop_front();
			it.last   = (text_buf.size() == 0);
			it.phase  = fill_phase;
			it.hold   = fill_hold;
			fill_hold = 1'b0;
			bytes_to_send.push_back(it);
		end
	endtask

	// One lexical token, biased towards keywords with their follow bytes so
	// that most texts actually move the depth.
	task automatic put_token();
		int         k;
		logic [7:0] q;
		case ($urandom_range(0, 11))
			0, 1, 2: begin
				k = $urandom_range(0, bnds_pkg::KW_COUNT - 1);
				put_word(k, KW_SIZE[k]);
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: put(valid_follow(k));
					6:                put("s");
					7:                put(rand_byte());
					8:                put(bnds_pkg::CH_LBRACE);
					default:          ;
				endcase
			end
			3: begin
				repeat ($urandom_range(1, 6))
					put(pick(WORD_POOL));
			end
			4: begin
				repeat ($urandom_range(1, 4))
					put(bnds_pkg::CH_LBRACE);
			end
			5: begin
				repeat ($urandom_range(1, 3))
					put(bnds_pkg::CH_RBRACE);
			end
			6: begin
				// Quoted string, sometimes left open, with escapes and bytes
				// that would matter outside it.
				q = ($urandom_range(0, 1) != 0) ? bnds_pkg::CH_DQUOTE : bnds_pkg::CH_SQUOTE;
				put(q);
				repeat ($urandom_range(0, 6)) begin
					case ($urandom_range(0, 5))
						0:       put(bnds_pkg::CH_BSLASH);
						1:       put(bnds_pkg::CH_DQUOTE ^ bnds_pkg::CH_SQUOTE ^ q);
						2:       put(bnds_pkg::CH_HASH);
						3:       put(bnds_pkg::CH_LBRACE);
						4:       put(rand_byte());
						default: put(pick(WORD_POOL));
					endcase
				end
				if ($urandom_range(0, 7) != 0)
					put(q);
			end
			7: begin
				put(bnds_pkg::CH_HASH);
				repeat ($urandom_range(0, 5))
					put(($urandom_range(0, 1) != 0) ? bnds_pkg::CH_LBRACE : rand_byte());
				if ($urandom_range(0, 5) != 0)
					put(bnds_pkg::CH_NL);
			end
			8:  put(pick(SPACE_POOL));
			9:  put(rand_byte());
			10: begin
				// Keyword cut short.
				k = $urandom_range(0, bnds_pkg::KW_COUNT - 1);
				put_word(k, $urandom_range(1, KW_SIZE[k] - 1));
			end
			default: put(pick(PUNCT_POOL));
		endcase
	endtask

	task automatic add_random_text();
		repeat ($urandom_range(1, 12))
			put_token();
		flush_text();
	endtask

	function automatic int gap_percent(input phase_t ph);
		if (ph == PH_SEND_GAPS)
			return 45;
		else if (ph == PH_BOTH)
			return 36;
		return 0;
	endfunction

	function automatic int stall_percent(input phase_t ph);
		if (ph == PH_RECV_STALLS)
			return 45;
		else if (ph == PH_BOTH)
			return 36;
		return 0;
	endfunction

	// -----------------------------------------------------------------------
	// Clock.
	// -----------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// -----------------------------------------------------------------------
	// Driver. An item is taken at an edge where tvalid and tready are both
	// high; that is the moment the model is advanced. A new item is offered
	// only once the previous one has gone, so tvalid never drops while an
	// item is waiting.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'h00;
			s_tlast  <= 1'b0;
		end else begin
			drv_busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				levels_due.push_back(level_after_byte(s_tdata, s_tlast));
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (bytes_to_send.size() != 0) begin
					head_item = bytes_to_send[0];
				end
				if (bytes_to_send.size() != 0
						&& (!head_item.hold || levels_due.size() == 0)
						&& $urandom_range(0, 99) >= gap_percent(head_item.phase)) begin
					head_item  = bytes_to_send.pop_front();
					s_tvalid   <= 1'b1;
					s_tdata    <= head_item.data;
					s_tlast    <= head_item.last;
					idle_phase <= head_item.phase;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Monitor. Every level item taken is checked against the oldest
	// prediction; tready is redrawn each cycle according to the shape.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (levels_due.size() == 0) begin
					$display("%0t: level item with none outstanding, expected none, actual %0d",
						$time, m_tdata);
					mismatch_count++;
				end else begin
					want_level = levels_due.pop_front();
					if (m_tdata !== want_level) begin
						$display("%0t: level mismatch, expected %0d, actual %0d",
							$time, want_level, m_tdata);
						mismatch_count++;
					end
				end
			end
			m_tready <= ($urandom_range(0, 99) >= stall_percent(idle_phase));
		end
	end

	// -----------------------------------------------------------------------
	// Stimulus, reset and end of run.
	// -----------------------------------------------------------------------
	initial begin
		int goal;
		clear_scan_state();

		// Directed texts: do with a pipe and end with a bracket; a keyword
		// followed by a string holding an escaped quote and a hash, then a
		// closing brace that hits the floor; a comment hiding a brace, and
		// begin closing the text.
		put_str("do|end)");
		flush_text();
		put_str("if 'a\\'#'}}{");
		flush_text();
		put_str("#{\nbegin");
		flush_text();

		// Random texts in four traffic shapes. The first item of each shape
		// waits for the block to drain.
		for (int ph = 0; ph < 4; ph++) begin
			fill_phase = phase_t'(ph);
			fill_hold  = 1'b1;
			goal = bytes_to_send.size() + 180;
			while (bytes_to_send.size() < goal)
				add_random_text();
			if (ph == 2) begin
				// Run the depth into saturation, step down once, and let
				// end close the text.
				repeat (258)
					put(bnds_pkg::CH_LBRACE);
				put(bnds_pkg::CH_RBRACE);
				put_word(bnds_pkg::KW_END, KW_SIZE[bnds_pkg::KW_END]);
				flush_text();
			end
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_to_send.size() != 0 || s_tvalid)
			@(posedge clk);
		while (levels_due.size() != 0)
			@(posedge clk);
		// Catch any stray level item produced after the last one expected.
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ block_nesting_depth_scanner.f @@
rtl/bnds_pkg.sv
rtl/bnds_front.sv
rtl/bnds_queue.sv
rtl/bnds_back.sv
rtl/block_nesting_depth_scanner.sv
tb/block_nesting_depth_scanner_tb.sv
